@@ hdl/gic_pkg.sv @@
// ============================================================================
// Gamepad input conditioner package
// Shared types, constants and the key code to button table.
// ============================================================================
`default_nettype none

package gic_pkg;

  localparam int NUM_USERS_DEF = 4;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 15;
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_DZ = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_DZ = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TRIG_THR = 2'd2;
  localparam logic [14:0] LEFT_DZ_RST = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [7:0] TRIG_THR_RST = 8'd30;

  // Divider geometry: numerator is a 15-bit magnitude times 32767.
  localparam int MAG_W = 15;
  localparam int NUM_W = 2 * MAG_W;
  localparam int DIV_STEPS = MAG_W;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] num;
    logic [MAG_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic [15:0]      prev_buttons;
    logic [1:0]       prev_trig;
    logic [1:0]       trig_edges;   // bit 1 right, bit 0 left
    logic [15:0]      pressed;
    logic [3:0][15:0] sticks;       // 0 left x, 1 left y, 2 right x, 3 right y
  } entry_t;

  localparam logic [15:0] KEY_A = 16'h5800;
  localparam logic [15:0] KEY_B = 16'h5801;
  localparam logic [15:0] KEY_X = 16'h5802;
  localparam logic [15:0] KEY_Y = 16'h5803;
  localparam logic [15:0] KEY_RSHOULDER = 16'h5804;
  localparam logic [15:0] KEY_LSHOULDER = 16'h5805;
  localparam logic [15:0] KEY_DPAD_UP = 16'h5810;
  localparam logic [15:0] KEY_DPAD_DOWN = 16'h5811;
  localparam logic [15:0] KEY_DPAD_LEFT = 16'h5812;
  localparam logic [15:0] KEY_DPAD_RIGHT = 16'h5813;
  localparam logic [15:0] KEY_START = 16'h5814;
  localparam logic [15:0] KEY_BACK = 16'h5815;
  localparam logic [15:0] KEY_LTHUMB = 16'h5816;
  localparam logic [15:0] KEY_RTHUMB = 16'h5817;

  function automatic logic [15:0] key_to_button(input logic [15:0] code);
    logic [15:0] b;
    case (code)
      KEY_A:          b = 16'h1000;
      KEY_B:          b = 16'h2000;
      KEY_X:          b = 16'h4000;
      KEY_Y:          b = 16'h8000;
      KEY_RSHOULDER:  b = 16'h0200;
      KEY_LSHOULDER:  b = 16'h0100;
      KEY_DPAD_UP:    b = 16'h0001;
      KEY_DPAD_DOWN:  b = 16'h0002;
      KEY_DPAD_LEFT:  b = 16'h0004;
      KEY_DPAD_RIGHT: b = 16'h0008;
      KEY_START:      b = 16'h0010;
      KEY_BACK:       b = 16'h0020;
      KEY_LTHUMB:     b = 16'h0040;
      KEY_RTHUMB:     b = 16'h0080;
      default:        b = 16'h0000;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

@@ hdl/gic_ram.sv @@
// ============================================================================
// Generic RAM
// One write port, one read port, read data registered.
// ============================================================================
`default_nettype none

module gic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0]      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/gic_div.sv @@
// ============================================================================
// Radix-2 divider
// Restoring division of a 30-bit numerator by a 15-bit divisor, one quotient
// bit per cycle. The quotient must fit in 15 bits.
// ============================================================================
`default_nettype none

module gic_div (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire gic_pkg::div_req_t              req,
  output logic                                done,
  output logic [gic_pkg::MAG_W-1:0]           quotient
);

  localparam int W = gic_pkg::MAG_W;
  localparam int CNT_W = $clog2(gic_pkg::DIV_STEPS + 1);

  logic [W-1:0]     rem_r;
  logic [W-1:0]     numlo_r;
  logic [W-1:0]     den_r;
  logic [W-1:0]     quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [W:0]   trial;
  logic         ge;
  logic [W-1:0] rem_nxt;

  // The upper half of the numerator is already below the divisor, so only
  // the lower half produces quotient bits.
  always_comb begin
    trial = {rem_r, numlo_r[W-1]};
    ge = (trial >= {1'b0, den_r});
    rem_nxt = ge ? W'(trial - {1'b0, den_r}) : trial[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= !req.start && busy_r && (cnt_r == CNT_W'(1));
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r <= CNT_W'(gic_pkg::DIV_STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num[gic_pkg::NUM_W-1:W];
      numlo_r <= req.num[W-1:0];
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      numlo_r <= {numlo_r[W-2:0], 1'b0};
      quo_r <= {quo_r[W-2:0], ge};
    end
  end

  assign done = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

@@ hdl/gamepad_input_conditioner.sv @@
// ============================================================================
// Gamepad input conditioner
// Per-controller button edge detection, stick dead-zone scaling and trigger
// edge detection, with the per-controller state held in a small RAM.
// ============================================================================
// One input beat is one poll of one controller; every accepted beat yields
// one result beat. A connected poll passes, from acceptance to the next
// acceptance, through one RAM read, then the four stick axes in turn
// through a single shared radix-2 divider, then a write-back. A
// disconnected poll replays the stored result without the divider. The
// result sits in an output register, so a new beat is taken while an
// earlier result still waits; the block waits at the end of an item only
// if that register is still full. After reset every controller reads as
// all zero without any clearing pass.
`default_nettype none

module gamepad_input_conditioner #(
  parameter int NUM_USERS = gic_pkg::NUM_USERS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // configuration
  input  wire logic                             cfg_write_en,
  input  wire logic [gic_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [gic_pkg::CFG_DATA_W-1:0]   cfg_data,
  // poll beats
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [1:0]                       in_user_index,
  input  wire logic                             in_connected,
  input  wire logic [15:0]                      in_buttons,
  input  wire logic [7:0]                       in_left_trigger,
  input  wire logic [7:0]                       in_right_trigger,
  input  wire logic signed [15:0]               in_left_x,
  input  wire logic signed [15:0]               in_left_y,
  input  wire logic signed [15:0]               in_right_x,
  input  wire logic signed [15:0]               in_right_y,
  input  wire logic                             in_key_valid,
  input  wire logic                             in_key_repeat,
  input  wire logic [15:0]                      in_virtual_key,
  // result beats
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic [15:0]                           out_pressed_buttons,
  output logic                                  out_left_trigger_pressed,
  output logic                                  out_right_trigger_pressed,
  output logic signed [15:0]                    out_left_x_scaled,
  output logic signed [15:0]                    out_left_y_scaled,
  output logic signed [15:0]                    out_right_x_scaled,
  output logic signed [15:0]                    out_right_y_scaled
);

  localparam int UIDX_W = (NUM_USERS > 1) ? $clog2(NUM_USERS) : 1;
  localparam int ENT_W = $bits(gic_pkg::entry_t);
  localparam int MW = gic_pkg::MAG_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_WAIT  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  localparam logic [1:0] K_ZERO = 2'd0;
  localparam logic [1:0] K_POS  = 2'd1;
  localparam logic [1:0] K_NEG  = 2'd2;

  // Configuration registers.
  logic [14:0] left_dz_r;
  logic [14:0] right_dz_r;
  logic [7:0]  trig_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_dz_r <= gic_pkg::LEFT_DZ_RST;
      right_dz_r <= gic_pkg::RIGHT_DZ_RST;
      trig_thr_r <= gic_pkg::TRIG_THR_RST;
    end else if (cfg_write_en) begin
      case (cfg_index)
        gic_pkg::CFG_LEFT_DZ:  left_dz_r <= cfg_data;
        gic_pkg::CFG_RIGHT_DZ: right_dz_r <= cfg_data;
        gic_pkg::CFG_TRIG_THR: trig_thr_r <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Control and captured beat.
  logic [2:0]       state_r;
  logic [1:0]       ax_r;
  logic [1:0]       kind_r;
  logic             out_valid_r;
  logic [NUM_USERS-1:0] written_r;

  logic [UIDX_W-1:0] idx_r;
  logic              conn_r;
  logic [15:0]       btn_r;
  logic [7:0]        lt_r;
  logic [7:0]        rt_r;
  logic [3:0][15:0]  axis_r;
  logic              kv_r;
  logic              kr_r;
  logic [15:0]       vk_r;

  gic_pkg::entry_t   ent_r;
  logic [3:0][15:0]  stick_r;
  gic_pkg::entry_t   res_r;

  logic              accept;
  logic [UIDX_W-1:0] in_idx;
  logic [ENT_W-1:0]  ram_rdata;
  logic              ram_we;
  gic_pkg::entry_t   new_ent;
  gic_pkg::entry_t   fin_res;
  logic              out_free;
  logic              fin_go;

  assign accept = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  // An index past the last controller falls back to controller 0.
  assign in_idx = (32'(in_user_index) < NUM_USERS) ? UIDX_W'(in_user_index) : '0;
  assign out_free = !out_valid_r || !out_stall;
  assign fin_go = (state_r == S_FIN) && out_free;
  assign ram_we = fin_go && conn_r;

  gic_ram #(
    .WIDTH(ENT_W),
    .DEPTH(NUM_USERS)
  ) u_state_ram (
    .clk(clk),
    .we(ram_we),
    .waddr(idx_r),
    .wdata(new_ent),
    .re(accept),
    .raddr(in_idx),
    .rdata(ram_rdata)
  );

  // Axis operand for the divider.
  logic [14:0]        dz;
  logic signed [16:0] vs;
  logic signed [16:0] ds;
  logic signed [16:0] xp;
  logic signed [16:0] xn;
  logic               is_pos;
  logic               is_neg;
  logic               den_zero;
  logic [MW-1:0]      mag;
  gic_pkg::div_req_t  div_req;
  logic               div_done;
  logic [MW-1:0]      div_q;
  logic [15:0]        axis_res;

  always_comb begin
    dz = ax_r[1] ? right_dz_r : left_dz_r;
    vs = 17'(signed'(axis_r[ax_r]));
    ds = signed'({2'b00, dz});
    xp = vs - ds;
    xn = -vs - ds - 17'sd1;
    is_pos = (vs > ds);
    is_neg = (vs < -ds);
    den_zero = (dz == {MW{1'b1}});
    mag = is_pos ? xp[MW-1:0] : xn[MW-1:0];
    div_req.start = (state_r == S_START);
    // mag * 32767 as a shift and subtract
    div_req.num = {mag, {MW{1'b0}}} - {{MW{1'b0}}, mag};
    // 32767 - dz is the bitwise complement in 15 bits
    div_req.den = den_zero ? MW'(1) : ~dz;
  end

  gic_div u_div (
    .clk(clk),
    .rst_n(rst_n),
    .req(div_req),
    .done(div_done),
    .quotient(div_q)
  );

  always_comb begin
    case (kind_r)
      K_POS:   axis_res = {1'b0, div_q};
      K_NEG:   axis_res = 16'd0 - {1'b0, div_q};
      default: axis_res = 16'd0;
    endcase
  end

  // Update of the controller entry.
  logic       lt_on;
  logic       rt_on;
  logic [15:0] pressed;

  always_comb begin
    lt_on = (lt_r > trig_thr_r);
    rt_on = (rt_r > trig_thr_r);
    pressed = btn_r & ~ent_r.prev_buttons;
    new_ent.prev_buttons = btn_r;
    new_ent.sticks = stick_r;
    new_ent.prev_trig = ent_r.prev_trig;
    new_ent.trig_edges = ent_r.trig_edges;
    // Trigger history only moves on frames that carry a keystroke.
    if (kv_r) begin
      if (kr_r) begin
        pressed = pressed | gic_pkg::key_to_button(vk_r);
      end
      new_ent.trig_edges = {rt_on && !ent_r.prev_trig[1], lt_on && !ent_r.prev_trig[0]};
      new_ent.prev_trig = {rt_on, lt_on};
    end
    new_ent.pressed = pressed;
    fin_res = conn_r ? new_ent : ent_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      written_r <= '0;
      ax_r <= '0;
    end else begin
      out_valid_r <= fin_go || (out_valid_r && out_stall);
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_READ;
          end
        end
        S_READ: begin
          ax_r <= '0;
          state_r <= conn_r ? S_START : S_FIN;
        end
        S_START: begin
          state_r <= S_WAIT;
        end
        S_WAIT: begin
          if (div_done) begin
            ax_r <= ax_r + 1'b1;
            state_r <= (ax_r == 2'd3) ? S_FIN : S_START;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state_r <= S_IDLE;
            if (conn_r) begin
              written_r[idx_r] <= 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      idx_r <= in_idx;
      conn_r <= in_connected;
      btn_r <= in_buttons;
      lt_r <= in_left_trigger;
      rt_r <= in_right_trigger;
      axis_r <= {in_right_y, in_right_x, in_left_y, in_left_x};
      kv_r <= in_key_valid;
      kr_r <= in_key_repeat;
      vk_r <= in_virtual_key;
    end
    // An entry never written since reset reads as zero.
    if (state_r == S_READ) begin
      ent_r <= written_r[idx_r] ? gic_pkg::entry_t'(ram_rdata) : '0;
    end
    if (state_r == S_START) begin
      kind_r <= den_zero ? K_ZERO : (is_pos ? K_POS : (is_neg ? K_NEG : K_ZERO));
    end
    if (state_r == S_WAIT && div_done) begin
      stick_r[ax_r] <= axis_res;
    end
    if (fin_go) begin
      res_r <= fin_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pressed_buttons = res_r.pressed;
  assign out_left_trigger_pressed = res_r.trig_edges[0];
  assign out_right_trigger_pressed = res_r.trig_edges[1];
  assign out_left_x_scaled = res_r.sticks[0];
  assign out_left_y_scaled = res_r.sticks[1];
  assign out_right_x_scaled = res_r.sticks[2];
  assign out_right_y_scaled = res_r.sticks[3];

endmodule

`default_nettype wire
